/* hw/rtl/two_tier_lru_write_back_cache_defines.svh */
// Assertion macros for the two-tier cache. They vanish when SYNTH is defined.
`ifndef TWO_TIER_LRU_WRITE_BACK_CACHE_DEFINES_SVH
`define TWO_TIER_LRU_WRITE_BACK_CACHE_DEFINES_SVH
`ifndef SYNTH
`define TLC_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("tlc check failed");
`define TLC_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("tlc sequence check failed");
`else
`define TLC_ASSERT(lbl, prop)
`define TLC_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* hw/rtl/tlc_pkg.sv */
`default_nettype none
package tlc_pkg;

   localparam int CACHE_ENTRIES_DEF = 16;
   localparam int NVRAM_ENTRIES_DEF = 16;
   localparam int BLOCK_BITS_DEF    = 16;

   localparam int RANK_W = 8;
   localparam int CAP_W  = 9;
   localparam int WC_W   = 8;

   localparam logic [1:0] OP_READ   = 2'd0;
   localparam logic [1:0] OP_WRITE  = 2'd1;
   localparam logic [1:0] OP_FLUSH  = 2'd2;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   localparam logic [1:0] CSR_CACHE_CAP = 2'd0;
   localparam logic [1:0] CSR_NVRAM_CAP = 2'd1;
   localparam logic [1:0] CSR_UNUSED    = 2'd3;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CSCAN,
      ST_CUPD,
      ST_FFIND,
      ST_FDEC,
      ST_NSCAN,
      ST_NUPD,
      ST_CWB,
      ST_DONE
   } state_type;

   // A capacity of zero behaves as one; anything above the entry count is clipped.
   function automatic logic [CAP_W-1:0] eff_cap(input logic [4:0] cap,
                                                input logic [CAP_W-1:0] entries);
      logic [CAP_W-1:0] c;
      c = {{(CAP_W-5){1'b0}}, cap};
      if (cap == 5'd0) return CAP_W'(1);
      if (c > entries) return entries;
      return c;
   endfunction

   // Recency rank of an entry that is neither the touched nor the inserted one.
   function automatic logic [RANK_W-1:0] new_rank(input logic [RANK_W-1:0] dr,
                                                  input logic hit,
                                                  input logic [RANK_W-1:0] re,
                                                  input logic evict,
                                                  input logic [RANK_W-1:0] rv);
      logic [RANK_W-1:0] r;
      r = dr;
      if (hit) begin
         if (dr < re) r = dr + 1'b1;
      end else begin
         if (evict && (dr > rv)) r = r - 1'b1;
         r = r + 1'b1;
      end
      return r;
   endfunction

endpackage
`default_nettype wire

/* hw/rtl/two_tier_lru_write_back_cache.sv */
// Two-tier LRU block cache with an NVRAM tier behind it. An item is taken when start is
// high and busy is low; exactly one result follows on rsp_valid for one cycle and cannot
// be held off. Each item walks the entry memories one entry per cycle: a read or write
// makes a tag scan then a rank update pass over the cache memory; an unused op goes
// straight to done. A flush finds each cached block in recency order by a cache pass,
// cleans a dirty one, and for each block placed in the NVRAM tier makes a scan and an
// update pass over the NVRAM memory. No clearing pass is needed after reset.
`default_nettype none
`include "two_tier_lru_write_back_cache_defines.svh"
module two_tier_lru_write_back_cache #(
   parameter int CACHE_ENTRIES = tlc_pkg::CACHE_ENTRIES_DEF,
   parameter int NVRAM_ENTRIES = tlc_pkg::NVRAM_ENTRIES_DEF,
   parameter int BLOCK_BITS    = tlc_pkg::BLOCK_BITS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  req_op,
   input  wire logic [15:0] req_block_id,
   output logic             rsp_valid,
   output logic             rsp_hit,
   output logic             rsp_write_miss,
   output logic             rsp_evicted_valid,
   output logic [15:0]      rsp_evicted_block,
   output logic             rsp_evicted_dirty,
   output logic [31:0]      rsp_storage_writes,
   output logic [31:0]      rsp_flushes_to_storage,
   output logic [31:0]      rsp_flushes_to_nvram,
   input  wire logic        csr_write_en,
   input  wire logic [1:0]  csr_index,
   input  wire logic [4:0]  csr_data
);
   import tlc_pkg::*;

   localparam int CAW = CACHE_ENTRIES > 1 ? $clog2(CACHE_ENTRIES) : 1;
   localparam int NAW = NVRAM_ENTRIES > 1 ? $clog2(NVRAM_ENTRIES) : 1;
   localparam int CCW = $clog2(CACHE_ENTRIES + 1);
   localparam int NCW = $clog2(NVRAM_ENTRIES + 1);
   localparam int PCW = $clog2((CACHE_ENTRIES > NVRAM_ENTRIES ?
                                CACHE_ENTRIES : NVRAM_ENTRIES) + 1);
   localparam int CMW = BLOCK_BITS + 1 + WC_W + CAW;
   localparam int NMW = BLOCK_BITS + NAW;
   localparam int C_WC = CAW;
   localparam int C_DT = CAW + WC_W;
   localparam int C_TG = CAW + WC_W + 1;

   state_type state_ff, state_in;
   logic [PCW-1:0] cnt_ff, cnt_in;
   logic [1:0] op_ff, op_in;
   logic [BLOCK_BITS-1:0] id_ff, id_in;
   logic [4:0] ccap_ff, ccap_in, ncap_ff, ncap_in;
   logic [CACHE_ENTRIES-1:0] cvalid_ff, cvalid_in;
   logic [NVRAM_ENTRIES-1:0] nvalid_ff, nvalid_in;
   logic [CCW-1:0] ccount_ff, ccount_in, ccount_m1;
   logic [NCW-1:0] ncount_ff, ncount_in;
   logic [CAW-1:0] r_ff, r_in, fidx_ff, fidx_in;
   logic [CMW-1:0] fword_ff, fword_in;
   logic hit_ff, hit_in, wmiss_ff, wmiss_in, evict_ff, evict_in;
   logic [BLOCK_BITS-1:0] evtag_ff, evtag_in;
   logic evdirty_ff, evdirty_in;
   logic [31:0] stw_ff, stw_in, sfl_ff, sfl_in, nfl_ff, nfl_in;
   logic rv_ff, rv_in, rhit_ff, rhit_in, rwm_ff, rwm_in, rev_ff, rev_in, revd_ff, revd_in;
   logic [15:0] reb_ff, reb_in;

   // Cache memory pipeline.
   logic c_issue, cpv_ff, c_we;
   logic [CAW-1:0] cpidx_ff, c_raddr, c_waddr;
   logic [CMW-1:0] c_rd, c_wd;
   // NVRAM memory pipeline.
   logic n_issue, npv_ff, n_we;
   logic [NAW-1:0] npidx_ff, n_raddr, n_waddr;
   logic [NMW-1:0] n_rd, n_wd;

   logic c_pass_end, n_pass_end;
   logic cs_found, cs_free_found, ns_found, ns_free_found;
   logic [CAW-1:0] cs_fidx, cs_frank, cs_free, cs_oidx, cs_orank;
   logic [NAW-1:0] ns_fidx, ns_frank, ns_free, ns_oidx, ns_orank;
   logic c_evict, n_evict;
   logic [CAW-1:0] c_slot;
   logic [NAW-1:0] n_slot;
   logic [BLOCK_BITS-1:0] ftag;
   logic [WC_W-1:0] fwc;

   assign ftag = fword_ff[CMW-1:C_TG];
   assign fwc  = fword_ff[C_DT-1:C_WC];

   tlc_ram #(.WIDTH(CMW), .DEPTH(CACHE_ENTRIES)) u_cache_ram (
      .clock(clock), .wr_en(c_we), .wr_addr(c_waddr), .wr_data(c_wd),
      .rd_addr(c_raddr), .rd_data(c_rd)
   );

   tlc_ram #(.WIDTH(NMW), .DEPTH(NVRAM_ENTRIES)) u_nvram_ram (
      .clock(clock), .wr_en(n_we), .wr_addr(n_waddr), .wr_data(n_wd),
      .rd_addr(n_raddr), .rd_data(n_rd)
   );

   tlc_lru_scan #(.AW(CAW), .TW(BLOCK_BITS)) u_cache_scan (
      .clock(clock), .reset(reset),
      .clear((state_in == ST_CSCAN) && (state_ff != ST_CSCAN)),
      .sample((state_ff == ST_CSCAN) && cpv_ff),
      .idx(cpidx_ff), .ent_valid(cvalid_ff[cpidx_ff]),
      .tag(c_rd[CMW-1:C_TG]), .rank(c_rd[CAW-1:0]), .id(id_ff),
      .found(cs_found), .found_idx(cs_fidx), .found_rank(cs_frank),
      .free_found(cs_free_found), .free_idx(cs_free),
      .old_idx(cs_oidx), .old_rank(cs_orank)
   );

   tlc_lru_scan #(.AW(NAW), .TW(BLOCK_BITS)) u_nvram_scan (
      .clock(clock), .reset(reset),
      .clear((state_in == ST_NSCAN) && (state_ff != ST_NSCAN)),
      .sample((state_ff == ST_NSCAN) && npv_ff),
      .idx(npidx_ff), .ent_valid(nvalid_ff[npidx_ff]),
      .tag(n_rd[NMW-1:NAW]), .rank(n_rd[NAW-1:0]), .id(ftag),
      .found(ns_found), .found_idx(ns_fidx), .found_rank(ns_frank),
      .free_found(ns_free_found), .free_idx(ns_free),
      .old_idx(ns_oidx), .old_rank(ns_orank)
   );

   assign c_pass_end = cnt_ff == PCW'(CACHE_ENTRIES);
   assign n_pass_end = cnt_ff == PCW'(NVRAM_ENTRIES);
   assign c_issue = ((state_ff == ST_CSCAN) || (state_ff == ST_CUPD) ||
                     (state_ff == ST_FFIND)) && (cnt_ff < PCW'(CACHE_ENTRIES));
   assign n_issue = ((state_ff == ST_NSCAN) || (state_ff == ST_NUPD)) &&
                    (cnt_ff < PCW'(NVRAM_ENTRIES));
   assign c_raddr = cnt_ff[CAW-1:0];
   assign n_raddr = cnt_ff[NAW-1:0];
   assign ccount_m1 = ccount_ff - 1'b1;

   // Victim and insertion slot; the freed victim is reused unless a lower slot is free.
   assign c_evict = !cs_found &&
                    (CAP_W'(ccount_ff) >= eff_cap(ccap_ff, CAP_W'(CACHE_ENTRIES)));
   assign c_slot  = (c_evict && !(cs_free_found && (cs_free < cs_oidx))) ? cs_oidx : cs_free;
   assign n_evict = !ns_found &&
                    (CAP_W'(ncount_ff) >= eff_cap(ncap_ff, CAP_W'(NVRAM_ENTRIES)));
   assign n_slot  = (n_evict && !(ns_free_found && (ns_free < ns_oidx))) ? ns_oidx : ns_free;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               unique case (req_op)
                  OP_READ, OP_WRITE: state_in = ST_CSCAN;
                  OP_FLUSH: state_in = (ccount_ff == '0) ? ST_DONE : ST_FFIND;
                  default: state_in = ST_DONE;
               endcase
            end
         end
         ST_CSCAN: if (c_pass_end) state_in = ST_CUPD;
         ST_CUPD:  if (c_pass_end) state_in = ST_DONE;
         ST_FFIND: if (c_pass_end) state_in = ST_FDEC;
         ST_FDEC: begin
            if (!fword_ff[C_DT]) state_in = (r_ff == '0) ? ST_DONE : ST_FFIND;
            else if (fwc > WC_W'(1)) state_in = ST_NSCAN;
            else state_in = ST_CWB;
         end
         ST_NSCAN: if (n_pass_end) state_in = ST_NUPD;
         ST_NUPD:  if (n_pass_end) state_in = ST_CWB;
         ST_CWB:   state_in = (r_ff == '0) ? ST_DONE : ST_FFIND;
         ST_DONE:  state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // Datapath and outputs.
   always_comb begin
      cnt_in     = (state_in != state_ff) ? '0 : cnt_ff + 1'b1;
      op_in      = op_ff;
      id_in      = id_ff;
      ccap_in    = ccap_ff;
      ncap_in    = ncap_ff;
      cvalid_in  = cvalid_ff;
      nvalid_in  = nvalid_ff;
      ccount_in  = ccount_ff;
      ncount_in  = ncount_ff;
      r_in       = r_ff;
      fidx_in    = fidx_ff;
      fword_in   = fword_ff;
      hit_in     = hit_ff;
      wmiss_in   = wmiss_ff;
      evict_in   = evict_ff;
      evtag_in   = evtag_ff;
      evdirty_in = evdirty_ff;
      stw_in     = stw_ff;
      sfl_in     = sfl_ff;
      nfl_in     = nfl_ff;
      rv_in      = 1'b0;
      rhit_in    = rhit_ff;
      rwm_in     = rwm_ff;
      rev_in     = rev_ff;
      revd_in    = revd_ff;
      reb_in     = reb_ff;
      c_we       = 1'b0;
      c_waddr    = cpidx_ff;
      c_wd       = c_rd;
      n_we       = 1'b0;
      n_waddr    = npidx_ff;
      n_wd       = n_rd;

      if (csr_write_en) begin
         case (csr_index)
            CSR_CACHE_CAP: ccap_in = csr_data;
            CSR_NVRAM_CAP: ncap_in = csr_data;
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               op_in    = req_op;
               id_in    = BLOCK_BITS'(req_block_id);
               hit_in   = 1'b0;
               wmiss_in = 1'b0;
               evict_in = 1'b0;
               r_in     = ccount_m1[CAW-1:0];
            end
         end
         ST_CUPD: begin
            if (cpv_ff) begin
               if (cs_found) begin
                  c_we = cvalid_ff[cpidx_ff];
                  if (cpidx_ff == cs_fidx) begin
                     c_wd[CAW-1:0] = '0;
                     if (op_ff == OP_WRITE) begin
                        c_wd[C_DT] = 1'b1;
                        if (c_rd[C_DT-1:C_WC] != {WC_W{1'b1}})
                           c_wd[C_DT-1:C_WC] = c_rd[C_DT-1:C_WC] + 1'b1;
                     end
                  end else begin
                     c_wd[CAW-1:0] = CAW'(new_rank(RANK_W'(c_rd[CAW-1:0]), 1'b1,
                                        RANK_W'(cs_frank), 1'b0, RANK_W'(cs_orank)));
                  end
               end else if (op_ff == OP_READ) begin
                  if (cpidx_ff == c_slot) begin
                     c_we = 1'b1;
                     c_wd = {id_ff, 1'b0, {WC_W{1'b0}}, {CAW{1'b0}}};
                  end else if (cvalid_ff[cpidx_ff] && !(c_evict && (cpidx_ff == cs_oidx))) begin
                     c_we = 1'b1;
                     c_wd[CAW-1:0] = CAW'(new_rank(RANK_W'(c_rd[CAW-1:0]), 1'b0,
                                        RANK_W'(cs_frank), c_evict, RANK_W'(cs_orank)));
                  end
                  if (c_evict && (cpidx_ff == cs_oidx)) begin
                     evtag_in   = c_rd[CMW-1:C_TG];
                     evdirty_in = c_rd[C_DT];
                  end
               end
            end
            if (c_pass_end) begin
               hit_in   = cs_found;
               wmiss_in = (op_ff == OP_WRITE) && !cs_found;
               if ((op_ff == OP_READ) && !cs_found) begin
                  evict_in = c_evict;
                  if (c_evict) cvalid_in[cs_oidx] = 1'b0;
                  else ccount_in = ccount_ff + 1'b1;
                  cvalid_in[c_slot] = 1'b1;
               end
            end
         end
         ST_FFIND: begin
            if (cpv_ff && cvalid_ff[cpidx_ff] && (c_rd[CAW-1:0] == r_ff)) begin
               fidx_in  = cpidx_ff;
               fword_in = c_rd;
            end
         end
         ST_FDEC: begin
            if (fword_ff[C_DT] && (fwc == WC_W'(1))) begin
               stw_in = stw_ff + 1'b1;
               sfl_in = sfl_ff + 1'b1;
            end
            if (!fword_ff[C_DT] && (r_ff != '0)) r_in = r_ff - 1'b1;
         end
         ST_NUPD: begin
            if (npv_ff) begin
               if (ns_found) begin
                  n_we = nvalid_ff[npidx_ff];
                  if (npidx_ff == ns_fidx) n_wd[NAW-1:0] = '0;
                  else n_wd[NAW-1:0] = NAW'(new_rank(RANK_W'(n_rd[NAW-1:0]), 1'b1,
                                          RANK_W'(ns_frank), 1'b0, RANK_W'(ns_orank)));
               end else if (npidx_ff == n_slot) begin
                  n_we = 1'b1;
                  n_wd = {ftag, {NAW{1'b0}}};
               end else if (nvalid_ff[npidx_ff] && !(n_evict && (npidx_ff == ns_oidx))) begin
                  n_we = 1'b1;
                  n_wd[NAW-1:0] = NAW'(new_rank(RANK_W'(n_rd[NAW-1:0]), 1'b0,
                                     RANK_W'(ns_frank), n_evict, RANK_W'(ns_orank)));
               end
            end
            if (n_pass_end) begin
               nfl_in = nfl_ff + 1'b1;
               if (!ns_found) begin
                  if (n_evict) begin
                     nvalid_in[ns_oidx] = 1'b0;
                     stw_in = stw_ff + 1'b1;
                  end else begin
                     ncount_in = ncount_ff + 1'b1;
                  end
                  nvalid_in[n_slot] = 1'b1;
               end
            end
         end
         ST_CWB: begin
            c_we    = 1'b1;
            c_waddr = fidx_ff;
            c_wd    = fword_ff;
            c_wd[C_DT]        = 1'b0;
            c_wd[C_DT-1:C_WC] = '0;
            if (r_ff != '0) r_in = r_ff - 1'b1;
         end
         ST_DONE: begin
            if (evict_ff && evdirty_ff) stw_in = stw_ff + 1'b1;
            rv_in   = 1'b1;
            rhit_in = hit_ff;
            rwm_in  = wmiss_ff;
            rev_in  = evict_ff;
            revd_in = evict_ff && evdirty_ff;
            reb_in  = evict_ff ? 16'(evtag_ff) : 16'd0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         cnt_ff    <= '0;
         ccap_ff   <= 5'd16;
         ncap_ff   <= 5'd16;
         cvalid_ff <= '0;
         nvalid_ff <= '0;
         ccount_ff <= '0;
         ncount_ff <= '0;
         stw_ff    <= '0;
         sfl_ff    <= '0;
         nfl_ff    <= '0;
         rv_ff     <= 1'b0;
         cpv_ff    <= 1'b0;
         npv_ff    <= 1'b0;
         hit_ff    <= 1'b0;
         wmiss_ff  <= 1'b0;
         evict_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         ccap_ff   <= ccap_in;
         ncap_ff   <= ncap_in;
         cvalid_ff <= cvalid_in;
         nvalid_ff <= nvalid_in;
         ccount_ff <= ccount_in;
         ncount_ff <= ncount_in;
         stw_ff    <= stw_in;
         sfl_ff    <= sfl_in;
         nfl_ff    <= nfl_in;
         rv_ff     <= rv_in;
         cpv_ff    <= c_issue;
         npv_ff    <= n_issue;
         hit_ff    <= hit_in;
         wmiss_ff  <= wmiss_in;
         evict_ff  <= evict_in;
      end
      op_ff      <= op_in;
      id_ff      <= id_in;
      r_ff       <= r_in;
      fidx_ff    <= fidx_in;
      fword_ff   <= fword_in;
      evtag_ff   <= evtag_in;
      evdirty_ff <= evdirty_in;
      cpidx_ff   <= c_raddr;
      npidx_ff   <= n_raddr;
      rhit_ff    <= rhit_in;
      rwm_ff     <= rwm_in;
      rev_ff     <= rev_in;
      revd_ff    <= revd_in;
      reb_ff     <= reb_in;
   end

   assign busy                   = state_ff != ST_IDLE;
   assign rsp_valid              = rv_ff;
   assign rsp_hit                = rhit_ff;
   assign rsp_write_miss         = rwm_ff;
   assign rsp_evicted_valid      = rev_ff;
   assign rsp_evicted_block      = reb_ff;
   assign rsp_evicted_dirty      = revd_ff;
   assign rsp_storage_writes     = stw_ff;
   assign rsp_flushes_to_storage = sfl_ff;
   assign rsp_flushes_to_nvram   = nfl_ff;

   `TLC_ASSERT(a_cache_count, $countones(cvalid_ff) == int'(ccount_ff))
   `TLC_ASSERT(a_nvram_count, $countones(nvalid_ff) == int'(ncount_ff))
   `TLC_ASSERT(a_evict_no_hit, rsp_valid |-> !(rsp_evicted_valid && rsp_hit))
   `TLC_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
endmodule
`default_nettype wire

/* hw/rtl/tlc_ram.sv */
`default_nettype none
module tlc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                   clock,
   input  wire logic                                   wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                       wr_data,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                       rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

/* hw/rtl/tlc_lru_scan.sv */
`default_nettype none
module tlc_lru_scan #(
   parameter int AW = 4,
   parameter int TW = 16
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          clear,
   input  wire logic          sample,
   input  wire logic [AW-1:0] idx,
   input  wire logic          ent_valid,
   input  wire logic [TW-1:0] tag,
   input  wire logic [AW-1:0] rank,
   input  wire logic [TW-1:0] id,
   output logic               found,
   output logic      [AW-1:0] found_idx,
   output logic      [AW-1:0] found_rank,
   output logic               free_found,
   output logic      [AW-1:0] free_idx,
   output logic      [AW-1:0] old_idx,
   output logic      [AW-1:0] old_rank
);
   logic          found_ff, found_in, free_ff, free_in, old_ff, old_in;
   logic [AW-1:0] fidx_ff, fidx_in, frank_ff, frank_in, free_idx_ff, free_idx_in;
   logic [AW-1:0] oidx_ff, oidx_in, orank_ff, orank_in;

   always_comb begin
      found_in    = found_ff;
      free_in     = free_ff;
      old_in      = old_ff;
      fidx_in     = fidx_ff;
      frank_in    = frank_ff;
      free_idx_in = free_idx_ff;
      oidx_in     = oidx_ff;
      orank_in    = orank_ff;
      if (clear) begin
         found_in = 1'b0;
         free_in  = 1'b0;
         old_in   = 1'b0;
      end else if (sample) begin
         if (ent_valid) begin
            if (!found_ff && (tag == id)) begin
               found_in = 1'b1;
               fidx_in  = idx;
               frank_in = rank;
            end
            // Strictly greater keeps the first entry on a tie.
            if (!old_ff || (rank > orank_ff)) begin
               old_in   = 1'b1;
               oidx_in  = idx;
               orank_in = rank;
            end
         end else if (!free_ff) begin
            free_in     = 1'b1;
            free_idx_in = idx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
         free_ff  <= 1'b0;
         old_ff   <= 1'b0;
      end else begin
         found_ff <= found_in;
         free_ff  <= free_in;
         old_ff   <= old_in;
      end
      fidx_ff     <= fidx_in;
      frank_ff    <= frank_in;
      free_idx_ff <= free_idx_in;
      oidx_ff     <= oidx_in;
      orank_ff    <= orank_in;
   end

   assign found      = found_ff;
   assign found_idx  = fidx_ff;
   assign found_rank = frank_ff;
   assign free_found = free_ff;
   assign free_idx   = free_idx_ff;
   assign old_idx    = oidx_ff;
   assign old_rank   = orank_ff;
endmodule
`default_nettype wire
